>>> src/ght_pkg.sv
// Generational handle table: shared types, action codes and constants.
// Used by ght_ctrl, ght_dp and generational_handle_table_unit.
package ght_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int IDX_W_IO        = 10;
  localparam int GEN_W           = 7;
  localparam int VAL_W           = 32;
  localparam int TAG_W           = GEN_W + 1;

  localparam logic [1:0] ACT_ALLOC  = 2'd0;
  localparam logic [1:0] ACT_FREE   = 2'd1;
  localparam logic [1:0] ACT_MODIFY = 2'd2;
  localparam logic [1:0] ACT_LOOKUP = 2'd3;

  localparam logic [VAL_W-1:0] FREE_VALUE = '1;
  localparam logic [GEN_W-1:0] GEN_RESET  = '1;

  typedef struct packed {
    logic [1:0]          action;
    logic [IDX_W_IO-1:0] slot_index;
    logic [GEN_W-1:0]    handle_generation;
    logic [VAL_W-1:0]    slot_value;
    logic                staged_flag;
  } in_t;

  typedef struct packed {
    logic                ok;
    logic [IDX_W_IO-1:0] out_index;
    logic [GEN_W-1:0]    out_generation;
    logic [VAL_W-1:0]    out_value;
    logic                out_staged;
  } out_t;

  // one table slot: tag (staged bit over generation) and value
  typedef struct packed {
    logic             staged;
    logic [GEN_W-1:0] gen;
    logic [VAL_W-1:0] value;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_wr;   // write reset entry at clear address
    logic accept;   // latch request, issue first read
    logic probe;    // allocate: advance to next slot, issue read
    logic finish;   // commit writes, load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic done;
    logic out_free;
  } sts_t;

endpackage

>>> src/ght_ctrl.sv
// Generational handle table: controller state machine.
// Depends on ght_pkg (cmd_t, sts_t).
module ght_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ght_pkg::sts_t sts,
  output ght_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!sts.done) begin
          cmd.probe = 1'b1;
        end else if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

>>> src/ght_dp.sv
// Generational handle table: datapath with slot memory, live count,
// allocate scan pointer and output register. Depends on ght_pkg.
module ght_dp #(
  parameter int TABLE_DEPTH = ght_pkg::DEF_TABLE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ght_pkg::in_t  in_data,
  input  ght_pkg::cmd_t cmd,
  output ght_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_ready,
  output ght_pkg::out_t out_data
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int EXT_W = IDX_W + ght_pkg::IDX_W_IO;

  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(TABLE_DEPTH - 1);
  localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(TABLE_DEPTH);

  ght_pkg::entry_t mem [TABLE_DEPTH];
  ght_pkg::entry_t rd_q;

  ght_pkg::in_t    req_r;
  logic            fail_r;
  logic [IDX_W-1:0] cur_r, clr_addr_r;
  logic [CNT_W-1:0] probe_r, count_r, count_nxt;
  logic            out_valid_r;
  ght_pkg::out_t   out_r, res;

  logic [EXT_W-1:0] idx_ext, slot_ext;
  logic [IDX_W-1:0] in_idx, first_addr, next_addr, rd_addr, wr_addr;
  logic             in_range, in_fail, rd_en, wr_en, wr_req;
  logic             slot_free, probe_last, is_alloc;
  ght_pkg::entry_t  wr_data, wr_entry;

  assign idx_ext  = {{IDX_W{1'b0}}, in_data.slot_index};
  assign in_idx   = idx_ext[IDX_W-1:0];
  assign in_range = idx_ext < DEPTH_EXT;

  always_comb begin
    if (in_data.action == ght_pkg::ACT_ALLOC) begin
      in_fail    = (in_data.slot_value == ght_pkg::FREE_VALUE) || (count_r >= DEPTH_CNT);
      first_addr = count_r[IDX_W-1:0];
    end else begin
      in_fail    = !in_range;
      first_addr = in_idx;
    end
  end

  assign next_addr = (cur_r == LAST_SLOT) ? '0 : cur_r + 1'b1;
  assign rd_en     = cmd.accept | cmd.probe;
  assign rd_addr   = cmd.accept ? first_addr : next_addr;

  assign is_alloc   = req_r.action == ght_pkg::ACT_ALLOC;
  assign slot_free  = rd_q.value == ght_pkg::FREE_VALUE;
  assign probe_last = probe_r == LAST_CNT;

  assign sts.done     = !is_alloc || fail_r || slot_free || probe_last;
  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.clr_last = clr_addr_r == LAST_SLOT;

  assign slot_ext = {{ght_pkg::IDX_W_IO{1'b0}}, cur_r};

  // result, table write and count update for the request under execution
  always_comb begin
    res       = '0;
    wr_req    = 1'b0;
    wr_entry  = rd_q;
    count_nxt = count_r;
    if (!fail_r) begin
      case (req_r.action)
        ght_pkg::ACT_ALLOC: begin
          if (slot_free) begin
            wr_req             = 1'b1;
            wr_entry.value     = req_r.slot_value;
            wr_entry.gen       = rd_q.gen + 1'b1;
            wr_entry.staged    = req_r.staged_flag;
            count_nxt          = count_r + 1'b1;
            res.ok             = 1'b1;
            res.out_index      = slot_ext[ght_pkg::IDX_W_IO-1:0];
            res.out_generation = rd_q.gen + 1'b1;
          end
        end
        ght_pkg::ACT_FREE: begin
          wr_req          = 1'b1;
          wr_entry.value  = ght_pkg::FREE_VALUE;
          wr_entry.staged = 1'b0;
          if (!slot_free && count_r != '0) begin
            count_nxt = count_r - 1'b1;
          end
          res.ok = 1'b1;
        end
        ght_pkg::ACT_MODIFY: begin
          wr_req          = 1'b1;
          wr_entry.value  = req_r.slot_value;
          wr_entry.staged = req_r.staged_flag;
          res.ok          = 1'b1;
        end
        ght_pkg::ACT_LOOKUP: begin
          if (rd_q.gen == req_r.handle_generation) begin
            res.ok             = 1'b1;
            res.out_index      = req_r.slot_index;
            res.out_generation = rd_q.gen;
            res.out_value      = rd_q.value;
            res.out_staged     = rd_q.staged;
          end
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  always_comb begin
    wr_en   = cmd.clr_wr | (cmd.finish & wr_req);
    wr_addr = cmd.clr_wr ? clr_addr_r : cur_r;
    if (cmd.clr_wr) begin
      wr_data = '{staged: 1'b0, gen: ght_pkg::GEN_RESET, value: ght_pkg::FREE_VALUE};
    end else begin
      wr_data = wr_entry;
    end
  end

  // slot memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r   <= in_data;
      fail_r  <= in_fail;
      cur_r   <= first_addr;
      probe_r <= '0;
    end else if (cmd.probe) begin
      cur_r   <= next_addr;
      probe_r <= probe_r + 1'b1;
    end
    if (cmd.finish) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cmd.finish) begin
        count_r <= count_nxt;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> src/generational_handle_table_unit.sv
// Generational handle table, top level: controller plus datapath.
// Free, modify and lookup: the slot is read, then the result is registered
// once the output register is free; a new request is taken only after the
// last one finishes. Allocate: occupied slots are probed until a free one
// (one slot read per cycle, single read port), at most TABLE_DEPTH slots.
// Clearing after reset writes every slot, in_ready low. Depends on ght_pkg.
module generational_handle_table_unit #(
  parameter int TABLE_DEPTH = ght_pkg::DEF_TABLE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ght_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ght_pkg::out_t out_data
);

  ght_pkg::cmd_t cmd;
  ght_pkg::sts_t sts;

  // controller: clear pass, accept, allocate probe loop, commit
  ght_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: slot memory, live count, output register (lets the next
  // transfer in while a result still waits)
  ght_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
